// ===== rtl/tsc_pkg.sv =====
// Shared constants and types for the Taylor sine/cosine block.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  // Series length cap and the widths that follow from it
  localparam int MAX_TERMS = 24;
  localparam int N_W       = $clog2(MAX_TERMS + 1);
  localparam int DEN_MAX   = 2 * MAX_TERMS * (2 * MAX_TERMS + 1);
  localparam int DEN_W     = $clog2(DEN_MAX + 1);

  // Port field widths
  localparam int ANGLE_W = 32;
  localparam int THR_W   = 31;
  localparam int VALUE_W = 32;
  localparam int TERMS_W = 5;

  // Datapath widths
  localparam int M_W      = 33;  // signed angle magnitude during wrap
  localparam int MAG_W    = 24;  // |angle| after wrap, at most 180 deg in Q16
  localparam int RAD_W    = 32;  // |radians| in Q30, at most pi
  localparam int X2_W     = 34;  // x^2 in Q30, at most pi^2
  localparam int X2_SPLIT = 15;  // x^2 split into high and low parts
  localparam int TM_W     = 33;  // term magnitude in Q30
  localparam int PACC_W   = TM_W + X2_W - X2_SPLIT;
  localparam int SUM_W    = 40;  // running sum, signed Q30
  localparam int FRAC_W   = 30;

  // Shared multiplier
  localparam int MA_W   = 33;
  localparam int MB_W   = 32;
  localparam int PROD_W = MA_W + MB_W;

  // Shared divider: quotient bits and dividend width
  localparam int Q_W    = 33;
  localparam int DIVD_W = Q_W + DEN_W;
  localparam int QC_W   = $clog2(Q_W + 1);

  // Angle constants: 180 deg in Q16 is 45 * 2^18
  localparam int HALF_TURN_ODD = 45;
  localparam int RAD_SHIFT     = 18;
  localparam int HALF_TURN     = HALF_TURN_ODD << RAD_SHIFT;
  localparam int FULL_TURN     = 2 * HALF_TURN;
  localparam int WRAP_STEPS    = 7;  // binary steps of the 360 deg reduction
  localparam int STEP_W        = $clog2(WRAP_STEPS);

  localparam logic [RAD_W-1:0] PI_Q30    = 32'd3373259426;
  localparam logic [TM_W-1:0]  ONE_Q30   = TM_W'(1) << FRAC_W;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1074);

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sequencer status toward the handshake logic
  typedef struct packed {
    logic idle;
    logic fin_valid;
  } seq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tsc_mul.sv =====
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module tsc_mul import tsc_pkg::*; (
  input  logic              clk,
  input  logic [MA_W-1:0]   a,
  input  logic [MB_W-1:0]   b,
  output logic [PROD_W-1:0] prod
);

  // One product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/tsc_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tsc_div import tsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic [Q_W-1:0]    quotient,
  output div_stat_t         stat
);

  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   quo;
  logic [DEN_W-1:0] dvs;
  logic [QC_W-1:0]  cnt;
  logic             done;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Trial subtract; the upper dividend part is always below the divisor
  always_comb begin
    shifted = {rem, quo[Q_W-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = !diff[DEN_W];
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == QC_W'(1));
      if (start) begin
        cnt <= QC_W'(Q_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DIVD_W-1:Q_W];
      quo <= dividend[Q_W-1:0];
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[Q_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== rtl/tsc_seq.sv =====
// Sequencer and datapath registers: angle wrap, radians, series loop.
`timescale 1ns / 1ps
`default_nettype none

module tsc_seq import tsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_take,
  input  logic                      func,
  input  logic signed [ANGLE_W-1:0] angle_deg,
  input  logic [THR_W-1:0]          threshold,
  input  logic                      fin_take,
  output seq_stat_t                 stat,
  output logic [VALUE_W-1:0]        fin_value,
  output logic [TERMS_W-1:0]        fin_terms,
  output logic                      fin_limit
);

  localparam int T_W = PACC_W + 2;
  localparam logic signed [M_W-1:0]   HALF_C = M_W'(HALF_TURN);
  localparam logic signed [M_W-1:0]   FULL_C = M_W'(FULL_TURN);
  localparam logic signed [SUM_W-1:0] VMAX =
    {{(SUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] VMIN =
    {{(SUM_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_WRAP  = 14'h0002,
    S_FOLD  = 14'h0004,
    S_SIGN  = 14'h0008,
    S_RMUL  = 14'h0010,
    S_RDIV  = 14'h0020,
    S_RWAIT = 14'h0040,
    S_SQ    = 14'h0080,
    S_SQR   = 14'h0100,
    S_TMH   = 14'h0200,
    S_TML   = 14'h0400,
    S_TDIV  = 14'h0800,
    S_TWAIT = 14'h1000,
    S_DONE  = 14'h2000
  } state_t;

  state_t state, state_next;

  // Datapath registers
  logic                    cos_r;
  logic                    sgn_r;
  logic signed [M_W-1:0]   m_r;
  logic [STEP_W-1:0]       step_r;
  logic                    neg_r;
  logic [MAG_W-1:0]        mag_r;
  logic [RAD_W-1:0]        rad_r;
  logic [X2_W-1:0]         x2_r;
  logic [TM_W-1:0]         tmag_r;
  logic                    tneg_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [N_W-1:0]          cnt_r;
  logic [PACC_W-1:0]       pacc_r;
  logic                    limit_r;

  // Shared units
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DEN_W-1:0]  div_divisor;
  logic [Q_W-1:0]    div_q;
  div_stat_t         div_stat;

  tsc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  tsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Wrap step: subtract 360 deg scaled by 2^step if the result stays above 180 deg
  logic signed [M_W-1:0] full_sh;
  logic signed [M_W-1:0] cand;
  logic signed [M_W-1:0] m_abs;

  always_comb begin
    full_sh = FULL_C << step_r;
    cand    = m_r - full_sh;
    m_abs   = m_r[M_W-1] ? -m_r : m_r;
  end

  // Radian dividend: round half up of |deg| * pi / (180 * 2^16)
  logic [PROD_W-1:0] rad_sum;
  logic [DIVD_W-1:0] rad_divd;

  always_comb begin
    rad_sum  = mul_prod + PROD_W'(HALF_TURN / 2);
    rad_divd = DIVD_W'(rad_sum >> RAD_SHIFT);
  end

  // Denominator (2n)(2n+1) for sine or (2n)(2n-1) for cosine, n = count + 1
  logic [N_W-1:0]     n_cur;
  logic [N_W:0]       twon;
  logic [N_W:0]       fac;
  logic [2*N_W+1:0]   den_full;
  logic [DEN_W-1:0]   den;

  always_comb begin
    n_cur    = cnt_r + 1'b1;
    twon     = {n_cur, 1'b0};
    fac      = cos_r ? twon - 1'b1 : twon + 1'b1;
    den_full = twon * fac;
    den      = den_full[DEN_W-1:0];
  end

  // Term dividend: (a*bh + floor(a*bl / 2^15) + den * 2^14) / 2^15
  logic [T_W-1:0]    t_sum;
  logic [DIVD_W-1:0] term_divd;

  always_comb begin
    t_sum = T_W'(pacc_r) + T_W'(mul_prod[TM_W+X2_SPLIT-1:X2_SPLIT])
          + (T_W'(den) << (X2_SPLIT - 1));
    term_divd = DIVD_W'(t_sum >> X2_SPLIT);
  end

  // First term of the series
  logic [TM_W-1:0]         init_mag;
  logic                    init_neg;
  logic signed [SUM_W-1:0] init_ext;

  always_comb begin
    init_mag = cos_r ? ONE_Q30 : TM_W'(rad_r);
    init_neg = cos_r ? 1'b0 : neg_r;
    init_ext = $signed(SUM_W'(init_mag));
  end

  // New term: accumulate and stop tests
  logic signed [SUM_W-1:0] q_ext;
  logic signed [SUM_W-1:0] sum_upd;
  logic [N_W-1:0]          cnt_next;
  logic                    stop_thr;
  logic                    stop_cap;

  always_comb begin
    q_ext    = $signed(SUM_W'(div_q));
    sum_upd  = tneg_r ? sum_r + q_ext : sum_r - q_ext;
    cnt_next = cnt_r + 1'b1;
    stop_thr = div_q < TM_W'(threshold);
    stop_cap = cnt_next >= N_W'(MAX_TERMS);
  end

  // Operand selection for the shared units
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = term_divd;
    div_divisor  = den;
    unique case (state)
      S_RMUL: begin
        mul_a = MA_W'(mag_r);
        mul_b = PI_Q30;
      end
      S_RDIV: begin
        div_start    = 1'b1;
        div_dividend = rad_divd;
        div_divisor  = DEN_W'(HALF_TURN_ODD);
      end
      S_SQ: begin
        mul_a = MA_W'(rad_r);
        mul_b = rad_r;
      end
      S_TMH: begin
        mul_a = tmag_r;
        mul_b = MB_W'(x2_r[X2_W-1:X2_SPLIT]);
      end
      S_TML: begin
        mul_a = tmag_r;
        mul_b = MB_W'(x2_r[X2_SPLIT-1:0]);
      end
      S_TDIV: begin
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (item_take) state_next = S_WRAP;
      S_WRAP:  if (step_r == '0) state_next = S_FOLD;
      S_FOLD:  state_next = S_SIGN;
      S_SIGN:  state_next = S_RMUL;
      S_RMUL:  state_next = S_RDIV;
      S_RDIV:  state_next = S_RWAIT;
      S_RWAIT: if (div_stat.done) state_next = S_SQ;
      S_SQ:    state_next = S_SQR;
      S_SQR:   state_next = S_TMH;
      S_TMH:   state_next = S_TML;
      S_TML:   state_next = S_TDIV;
      S_TDIV:  state_next = S_TWAIT;
      S_TWAIT: begin
        if (div_stat.done) begin
          state_next = (stop_thr || stop_cap) ? S_DONE : S_TMH;
        end
      end
      S_DONE:  if (fin_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath register updates
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (item_take) begin
          cos_r  <= func;
          sgn_r  <= angle_deg[ANGLE_W-1];
          m_r    <= angle_deg[ANGLE_W-1] ? -M_W'(angle_deg) : M_W'(angle_deg);
          step_r <= STEP_W'(WRAP_STEPS - 1);
        end
      end
      S_WRAP: begin
        if (cand > HALF_C) m_r <= cand;
        step_r <= step_r - 1'b1;
      end
      S_FOLD: begin
        if (m_r > HALF_C) m_r <= m_r - FULL_C;
      end
      S_SIGN: begin
        // zero after the wrap counts as positive
        neg_r <= sgn_r ? ((m_r != '0) && !m_r[M_W-1]) : m_r[M_W-1];
        mag_r <= m_abs[MAG_W-1:0];
      end
      S_RWAIT: begin
        if (div_stat.done) rad_r <= div_q[RAD_W-1:0];
      end
      S_SQR: begin
        x2_r   <= X2_W'((mul_prod + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W);
        tmag_r <= init_mag;
        tneg_r <= init_neg;
        sum_r  <= init_neg ? -init_ext : init_ext;
        cnt_r  <= '0;
      end
      S_TML: begin
        pacc_r <= mul_prod[PACC_W-1:0];
      end
      S_TWAIT: begin
        if (div_stat.done) begin
          tmag_r  <= div_q;
          tneg_r  <= !tneg_r;
          cnt_r   <= cnt_next;
          sum_r   <= sum_upd;
          limit_r <= !stop_thr && stop_cap;
        end
      end
      default: ;
    endcase
  end

  // Saturated result and status
  always_comb begin
    if (sum_r > VMAX) begin
      fin_value = VMAX[VALUE_W-1:0];
    end else if (sum_r < VMIN) begin
      fin_value = VMIN[VALUE_W-1:0];
    end else begin
      fin_value = sum_r[VALUE_W-1:0];
    end
  end

  assign fin_terms      = TERMS_W'(cnt_r);
  assign fin_limit      = limit_r;
  assign stat.idle      = (state == S_IDLE);
  assign stat.fin_valid = (state == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/taylor_sine_cosine_degrees.sv =====
// Top level: handshakes, threshold register, result register, checks.
//
// Sine or cosine of an angle in Q15.16 degrees by a Taylor series.
// Input channel: item_valid / item_stall carry func and angle_deg; a
// transfer happens when item_valid is high and item_stall is low.
// Output channel: result_valid / result_stall carry result_value (Q1.30),
// terms_used and limit_hit; the downstream side holds result_stall high
// to keep a result, which then stays stable in the output register.
// Config channel: cfg_valid / cfg_ready write term_threshold (Q1.30).
// One item at a time: the angle wrap takes 7 + 1 steps, the radian
// conversion and x^2 each use the shared multiplier, the radian scaling
// and every series term use the shared 33-step divider. The next item is
// taken the cycle after the result moves to the output register, even if
// it stalls. Reset clears the sequencer and output valid and loads the
// threshold with its default of 1074.
`timescale 1ns / 1ps
`default_nettype none

module taylor_sine_cosine_degrees import tsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      func,
  input  logic signed [ANGLE_W-1:0] angle_deg,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [VALUE_W-1:0] result_value,
  output logic [TERMS_W-1:0]        terms_used,
  output logic                      limit_hit,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [THR_W-1:0]          term_threshold
);

  logic [THR_W-1:0]   thr;
  logic               item_take;
  logic               fin_take;
  seq_stat_t          seq_stat;
  logic [VALUE_W-1:0] fin_value;
  logic [TERMS_W-1:0] fin_terms;
  logic               fin_limit;

  // Threshold register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= term_threshold;
    end
  end

  // Input side
  assign item_stall = !seq_stat.idle;
  assign item_take  = item_valid && seq_stat.idle;

  tsc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .item_take (item_take),
    .func      (func),
    .angle_deg (angle_deg),
    .threshold (thr),
    .fin_take  (fin_take),
    .stat      (seq_stat),
    .fin_value (fin_value),
    .fin_terms (fin_terms),
    .fin_limit (fin_limit)
  );

  // Output register
  assign fin_take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (seq_stat.fin_valid && fin_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_stat.fin_valid && fin_take) begin
      result_value <= $signed(fin_value);
      terms_used   <= fin_terms;
      limit_hit    <= fin_limit;
    end
  end

  // Checks
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    item_take |=> !seq_stat.idle)
    else $error("sequencer still idle after an input transfer");

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (seq_stat.fin_valid && fin_take) |=> result_valid)
    else $error("finished result not presented");

  a_limit_cnt: assert property (@(posedge clk) disable iff (rst)
    (result_valid && limit_hit) |-> (terms_used == TERMS_W'(MAX_TERMS)))
    else $error("limit flag without a full term count");

endmodule

`default_nettype wire

// ===== verif/taylor_sine_cosine_degrees_test.sv =====
// Self-checking testbench for the Taylor-series sine/cosine block.
`timescale 1ns / 1ps

module taylor_sine_cosine_degrees_test;
  import tsc_pkg::*;

  // Function select as seen on the func port
  typedef enum logic {
    FN_SINE   = 1'b0,
    FN_COSINE = 1'b1
  } func_sel_t;

  // One result transfer
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [TERMS_W-1:0]        terms;
    logic                      limit;
  } trig_result_t;

  // One directed item; want is used only when typed is set
  typedef struct packed {
    logic [THR_W-1:0]          thr;
    func_sel_t                 fsel;
    logic signed [ANGLE_W-1:0] ang;
    logic                      typed;
    trig_result_t              want;
  } stim_row_t;

  localparam int DEG        = 65536;         // one degree in Q16
  localparam int N_DIRECTED = 24;
  localparam int N_PHASES   = 8;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_WAIT  = 1000;          // worst-case item latency plus margin

  localparam longint          DEG_HALF = 64'sd180 * DEG;
  localparam longint          DEG_FULL = 64'sd360 * DEG;
  localparam longint unsigned PI_FIX   = 64'd3373259426;  // pi in Q30

  localparam logic signed [VALUE_W-1:0] ONE_FIX = 32'sh4000_0000;
  localparam logic [TERMS_W-1:0]        CAP_TERMS = TERMS_W'(MAX_TERMS);
  localparam logic [THR_W-1:0]          THR_TOP   = '1;
  localparam logic [THR_W-1:0]          THR_ONE   = 31'h4000_0000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  logic                      func = FN_SINE;
  logic signed [ANGLE_W-1:0] angle_deg = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic signed [VALUE_W-1:0] result_value;
  logic [TERMS_W-1:0]        terms_used;
  logic                      limit_hit;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [THR_W-1:0]          term_threshold = THR_RESET;

  trig_result_t     expected_results [$];
  logic [THR_W-1:0] threshold_now = THR_RESET;
  int               mismatches = 0;
  int               cycle_count = 0;
  bit               tx_calm = 1'b0;
  bit               rx_calm = 1'b0;
  int               rx_hold;
  int               rx_draw;
  trig_result_t     rx_seen;
  trig_result_t     rx_want;
  stim_row_t        directed_rows [N_DIRECTED];

  taylor_sine_cosine_degrees DUT (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .func           (func),
    .angle_deg      (angle_deg),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result_value   (result_value),
    .terms_used     (terms_used),
    .limit_hit      (limit_hit),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .term_threshold (term_threshold)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Wrap to -180..180 deg, convert to Q30 radians, then sum the series
  function automatic trig_result_t taylor_sum(input logic want_cos,
                                              input logic signed [ANGLE_W-1:0] ang,
                                              input logic [THR_W-1:0] thr);
    longint          deg;
    longint          acc;
    longint unsigned span, k, mag, rad, x2, tmag, den, p, dv, n, cnt;
    bit              neg, tneg, done;
    trig_result_t    r;
    deg = ang;
    if (deg < -DEG_HALF) begin
      span = -DEG_HALF - deg;
      k = (span + DEG_FULL - 1) / DEG_FULL;
      deg += longint'(k) * DEG_FULL;
    end else if (deg > DEG_HALF) begin
      span = deg - DEG_HALF;
      k = (span + DEG_FULL - 1) / DEG_FULL;
      deg -= longint'(k) * DEG_FULL;
    end
    neg = deg < 0;
    mag = neg ? -deg : deg;
    rad = (mag * PI_FIX + DEG_HALF / 2) / DEG_HALF;
    x2 = (rad * rad + (64'd1 << 29)) >> 30;
    if (want_cos) begin
      tmag = 64'd1 << 30;
      tneg = 1'b0;
    end else begin
      tmag = rad;
      tneg = neg;
    end
    acc = tneg ? -longint'(tmag) : longint'(tmag);
    n = 1;
    cnt = 0;
    done = 1'b0;
    r.limit = 1'b0;
    while (!done) begin
      den = want_cos ? (2 * n) * (2 * n - 1) : (2 * n) * (2 * n + 1);
      // x^2 split into high and low parts at bit 15, as the datapath does it
      p = tmag * (x2 >> 15) + ((tmag * (x2 & 64'h7FFF)) >> 15);
      dv = den << 15;
      tmag = (p + dv / 2) / dv;
      tneg = !tneg;
      n++;
      cnt++;
      acc += tneg ? -longint'(tmag) : longint'(tmag);
      if (tmag < thr) begin
        done = 1'b1;
      end else if (cnt >= MAX_TERMS) begin
        r.limit = 1'b1;
        done = 1'b1;
      end
    end
    if (acc > longint'(32'h7FFF_FFFF)) acc = longint'(32'h7FFF_FFFF);
    if (acc < -longint'(32'h8000_0000)) acc = -longint'(32'h8000_0000);
    r.value = acc[31:0];
    r.terms = cnt[TERMS_W-1:0];
    return r;
  endfunction

  // Mixed angle draw: full range, a few turns, quarter turns, the wrap edges
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int q;
    q = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return ANGLE_W'($urandom_range(0, 800 * DEG)) - ANGLE_W'(400 * DEG);
      2: return ANGLE_W'(q * 90 * DEG + $urandom_range(0, 4) - 2);
      default: begin
        if ($urandom_range(0, 1) == 0)
          return ANGLE_W'(180 * DEG + $urandom_range(0, 4) - 2);
        return ANGLE_W'(-180 * DEG + $urandom_range(0, 4) - 2);
      end
    endcase
  endfunction

  // Drive one item, hold it until the transfer, then idle a random while
  task automatic send_item(input func_sel_t fsel, input logic signed [ANGLE_W-1:0] ang,
                           input trig_result_t want);
    int gap;
    item_valid <= 1'b1;
    func       <= fsel;
    angle_deg  <= ang;
    do @(posedge clk); while (item_stall);
    expected_results.push_back(want);
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every pending result has come back
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    cfg_valid      <= 1'b1;
    term_threshold <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    threshold_now = thr;
  endtask

  // Result side: random stall per result, compare against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      rx_hold      <= 0;
    end else if (result_valid && !result_stall) begin
      rx_seen = '{result_value, terms_used, limit_hit};
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: value %0d terms %0d limit %0d",
                   rx_seen.value, rx_seen.terms, rx_seen.limit);
        mismatches++;
      end else begin
        rx_want = expected_results.pop_front();
        if (rx_seen.value !== rx_want.value || rx_seen.terms !== rx_want.terms ||
            rx_seen.limit !== rx_want.limit) begin
          if (mismatches < 10)
            $display("mismatch: value %0d/%0d terms %0d/%0d limit %0d/%0d (exp/got)",
                     rx_want.value, rx_seen.value, rx_want.terms, rx_seen.terms,
                     rx_want.limit, rx_seen.limit);
          mismatches++;
        end
      end
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      rx_draw = rx_calm ? 0 : $urandom_range(0, 6);
      rx_hold      <= rx_draw;
      result_stall <= (rx_draw != 0);
    end else if (result_valid && rx_hold != 0) begin
      // count the stall down only while a result is waiting
      result_stall <= (rx_hold > 1);
      rx_hold      <= rx_hold - 1;
    end
  end

  // Directed items; expected values typed only for the obvious ones
  initial begin
    directed_rows = '{
      '{THR_RESET, FN_SINE,   32'sd0,                  1'b1, '{32'sd0, 5'd1, 1'b0}},
      '{THR_RESET, FN_COSINE, 32'sd0,                  1'b1, '{ONE_FIX, 5'd1, 1'b0}},
      '{THR_RESET, FN_SINE,   ANGLE_W'(360 * DEG),     1'b1, '{32'sd0, 5'd1, 1'b0}},
      '{THR_RESET, FN_COSINE, ANGLE_W'(-360 * DEG),    1'b1, '{ONE_FIX, 5'd1, 1'b0}},
      '{THR_RESET, FN_SINE,   ANGLE_W'(90 * DEG),      1'b0, '0},
      '{THR_RESET, FN_COSINE, ANGLE_W'(90 * DEG),      1'b0, '0},
      '{THR_RESET, FN_SINE,   ANGLE_W'(180 * DEG),     1'b0, '0},
      '{THR_RESET, FN_COSINE, ANGLE_W'(180 * DEG),     1'b0, '0},
      '{THR_RESET, FN_SINE,   ANGLE_W'(-180 * DEG),    1'b0, '0},
      '{THR_RESET, FN_COSINE, ANGLE_W'(-180 * DEG),    1'b0, '0},
      '{THR_RESET, FN_SINE,   ANGLE_W'(180 * DEG + 1), 1'b0, '0},
      '{THR_RESET, FN_SINE,   ANGLE_W'(-180 * DEG - 1), 1'b0, '0},
      '{THR_RESET, FN_SINE,   32'sh7FFF_FFFF,          1'b0, '0},
      '{THR_RESET, FN_COSINE, 32'sh8000_0000,          1'b0, '0},
      '{THR_RESET, FN_SINE,   -32'sd1,                 1'b0, '0},
      '{THR_RESET, FN_COSINE, 32'sd1,                  1'b0, '0},
      // zero threshold: never converges, runs to the cap
      '{31'd0,     FN_SINE,   32'sd0,                  1'b1, '{32'sd0, CAP_TERMS, 1'b1}},
      '{31'd0,     FN_COSINE, 32'sd0,                  1'b1, '{ONE_FIX, CAP_TERMS, 1'b1}},
      '{31'd0,     FN_SINE,   ANGLE_W'(45 * DEG),      1'b0, '0},
      '{31'd1,     FN_COSINE, ANGLE_W'(180 * DEG),     1'b0, '0},
      '{THR_TOP,   FN_SINE,   ANGLE_W'(180 * DEG),     1'b0, '0},
      '{THR_TOP,   FN_COSINE, ANGLE_W'(90 * DEG),      1'b0, '0},
      '{THR_ONE,   FN_SINE,   ANGLE_W'(-90 * DEG),     1'b0, '0},
      '{THR_ONE,   FN_COSINE, ANGLE_W'(180 * DEG),     1'b0, '0}
    };
  end

  // Main sequence
  initial begin
    logic [THR_W-1:0]          thr;
    logic signed [ANGLE_W-1:0] ang;
    func_sel_t                 fsel;
    int                        n_items;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].thr != threshold_now) begin
        drain();
        write_threshold(directed_rows[i].thr);
      end
      send_item(directed_rows[i].fsel, directed_rows[i].ang,
                directed_rows[i].typed ? directed_rows[i].want :
                taylor_sum(directed_rows[i].fsel, directed_rows[i].ang, threshold_now));
    end

    // Random phases, each under its own threshold
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: thr = 31'd1;
        1: thr = '0;
        2: thr = THR_ONE;
        3: thr = THR_TOP;
        7: thr = THR_RESET;
        default: begin
          thr = THR_W'($urandom) >> $urandom_range(0, 30);
          if (thr == 0) thr = 31'd1;
        end
      endcase
      n_items = (ph == 1) ? 80 : 130;  // zero threshold items are the slowest
      drain();
      write_threshold(thr);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) == 0) drain();
        fsel = func_sel_t'($urandom_range(0, 1));
        ang  = pick_angle();
        send_item(fsel, ang, taylor_sum(fsel, ang, threshold_now));
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tsc_pkg.sv
rtl/tsc_mul.sv
rtl/tsc_div.sv
rtl/tsc_seq.sv
rtl/taylor_sine_cosine_degrees.sv
verif/taylor_sine_cosine_degrees_test.sv
